[rtl/core/sbdft_pkg.sv]
package sbdft_pkg;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_WINDOW_SIZE = 1'b0,
    CFG_BIN         = 1'b1
  } cfg_reg_t;

  // Window size codes
  localparam logic [1:0] WIN_8  = 2'd0;
  localparam logic [1:0] WIN_16 = 2'd1;
  localparam logic [1:0] WIN_32 = 2'd2;

  // Bin codes
  localparam logic [1:0] BIN_0 = 2'd0;
  localparam logic [1:0] BIN_1 = 2'd1;
  localparam logic [1:0] BIN_2 = 2'd2;

  localparam logic [1:0] WIN_RESET = WIN_32;
  localparam logic [1:0] BIN_RESET = BIN_1;

  // Coefficient table
  localparam int         TABLE_SIZE = 32;
  localparam logic [4:0] TABLE_MASK = 5'(TABLE_SIZE - 1);
  localparam logic [4:0] SIN_OFFSET = 5'd24;

  // Coefficients are Q15 with one extra bit so that bin 0 can weight by 1.0
  localparam int                 COEF_W   = 17;
  localparam logic signed [16:0] COEF_ONE = 17'sd32768;

  // Sums are Q15; the result shift is 15 + log2(8) + window code
  localparam int SHIFT_BASE = 18;

  function automatic logic signed [15:0] cos_q15(input logic [4:0] idx);
    logic signed [15:0] c;
    case (idx)
      5'd0:    c = 16'sd32767;
      5'd1:    c = 16'sd32138;
      5'd2:    c = 16'sd30274;
      5'd3:    c = 16'sd27245;
      5'd4:    c = 16'sd23170;
      5'd5:    c = 16'sd18205;
      5'd6:    c = 16'sd12540;
      5'd7:    c = 16'sd6393;
      5'd8:    c = 16'sd0;
      5'd9:    c = -16'sd6393;
      5'd10:   c = -16'sd12540;
      5'd11:   c = -16'sd18205;
      5'd12:   c = -16'sd23170;
      5'd13:   c = -16'sd27245;
      5'd14:   c = -16'sd30274;
      5'd15:   c = -16'sd32138;
      5'd16:   c = -16'sd32767;
      5'd17:   c = -16'sd32138;
      5'd18:   c = -16'sd30274;
      5'd19:   c = -16'sd27245;
      5'd20:   c = -16'sd23170;
      5'd21:   c = -16'sd18205;
      5'd22:   c = -16'sd12540;
      5'd23:   c = -16'sd6393;
      5'd24:   c = 16'sd0;
      5'd25:   c = 16'sd6393;
      5'd26:   c = 16'sd12540;
      5'd27:   c = 16'sd18205;
      5'd28:   c = 16'sd23170;
      5'd29:   c = 16'sd27245;
      5'd30:   c = 16'sd30274;
      5'd31:   c = 16'sd32138;
      default: c = 16'sd0;
    endcase
    return c;
  endfunction

endpackage

[rtl/core/single_bin_dft_accumulator_top.sv]
// Single-bin DFT accumulator.
// Input channel (in_valid/in_ready/in_sample) carries one signed sample per
// transfer. Over a window of 8, 16 or 32 samples (cfg register 0) the block
// correlates the samples against cosine and minus sine of bin 0, 1 or 2
// (cfg register 1) and, after the last sample of the window, emits one
// result transfer on out_valid/out_ready with the real and imaginary sums
// divided by the window length (floor) and saturated to SAMPLE_BITS.
// Other samples produce no result.
// Throughput: one sample per cycle, sustained while no window-ending sample
// waits on a held result, set by the single multiply-accumulate stage.
// Result path: a window's last sample transfers into the input register,
// then the MAC result moves from there into the result register.
// Stall: the result register holds until out_ready; samples that do not end
// a window keep flowing meanwhile, a window-ending sample waits in the input
// register and in_ready drops behind it.
// Reset (rst_n low, synchronous): clears the sums, the sample index and both
// handshakes; window size returns to 32 and the bin to 1.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once
// and are meant to be issued while the block is idle.
module single_bin_dft_accumulator_top #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [1:0]                    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_real_part,
  output logic signed [SAMPLE_BITS-1:0] out_imag_part
);

  localparam int COEF_W = sbdft_pkg::COEF_W;
  localparam int PROD_W = SAMPLE_BITS + COEF_W;
  // 32 products of at most 2^(SAMPLE_BITS-1) * 2^15 plus a sign bit
  localparam int SUM_W  = SAMPLE_BITS + 21;

  localparam logic signed [SUM_W-1:0] SAT_MAX =
    {{(SUM_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

  // Configuration registers
  logic [1:0] window_sel_r;
  logic [1:0] bin_sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_sel_r <= sbdft_pkg::WIN_RESET;
      bin_sel_r    <= sbdft_pkg::BIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sbdft_pkg::CFG_WINDOW_SIZE: window_sel_r <= cfg_wdata;
        sbdft_pkg::CFG_BIN:         bin_sel_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Front end: window position, coefficient lookup, input register
  // ---------------------------------------------------------------------
  logic [1:0] win_eff;
  logic [1:0] bin_eff;
  logic [4:0] last_idx;
  logic       last_in;
  logic [1:0] tbl_shift;
  logic [4:0] tbl_idx;
  logic [4:0] sin_idx;
  logic signed [COEF_W-1:0] coef_re_nxt;
  logic signed [COEF_W-1:0] coef_im_nxt;
  logic       in_xfer;

  logic [4:0] sample_index_r;

  logic                          s1_v_r;
  logic                          s1_last_r;
  logic [1:0]                    s1_win_r;
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;
  logic signed [COEF_W-1:0]      s1_coef_re_r;
  logic signed [COEF_W-1:0]      s1_coef_im_r;
  logic                          s1_adv;

  // Select code 3 behaves as code 2 for both registers
  assign win_eff = (window_sel_r > sbdft_pkg::WIN_32) ? sbdft_pkg::WIN_32 : window_sel_r;
  assign bin_eff = (bin_sel_r > sbdft_pkg::BIN_2) ? sbdft_pkg::BIN_2 : bin_sel_r;

  always_comb begin
    case (win_eff)
      sbdft_pkg::WIN_8:  last_idx = 5'd7;
      sbdft_pkg::WIN_16: last_idx = 5'd15;
      default:           last_idx = 5'd31;
    endcase
  end

  // A shrunk window ends on the first sample at or past its last position
  assign last_in = (sample_index_r >= last_idx);

  // Table step is bin * 32/N, always a power of two: shift the index
  assign tbl_shift = 2'(2'd2 - win_eff) + 2'(bin_eff == sbdft_pkg::BIN_2);
  assign tbl_idx   = 5'(sample_index_r << tbl_shift) & sbdft_pkg::TABLE_MASK;
  assign sin_idx   = tbl_idx + sbdft_pkg::SIN_OFFSET;

  always_comb begin
    if (bin_eff == sbdft_pkg::BIN_0) begin
      // Mean: weight by exactly 1.0, no imaginary contribution
      coef_re_nxt = sbdft_pkg::COEF_ONE;
      coef_im_nxt = '0;
    end else begin
      coef_re_nxt = COEF_W'(sbdft_pkg::cos_q15(tbl_idx));
      coef_im_nxt = -COEF_W'(sbdft_pkg::cos_q15(sin_idx));
    end
  end

  // Only a window-ending sample needs the result register free
  assign s1_adv   = !s1_last_r || !out_valid || out_ready;
  assign in_ready = !s1_v_r || s1_adv;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_index_r <= '0;
      s1_v_r         <= 1'b0;
    end else begin
      if (in_xfer) begin
        sample_index_r <= last_in ? 5'd0 : sample_index_r + 5'd1;
      end
      if (in_ready) begin
        s1_v_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_last_r    <= last_in;
      s1_win_r     <= win_eff;
      s1_sample_r  <= in_sample;
      s1_coef_re_r <= coef_re_nxt;
      s1_coef_im_r <= coef_im_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Multiply-accumulate and result register
  // ---------------------------------------------------------------------
  logic signed [PROD_W-1:0] prod_re;
  logic signed [PROD_W-1:0] prod_im;
  logic signed [SUM_W-1:0]  sum_re;
  logic signed [SUM_W-1:0]  sum_im;
  logic signed [SUM_W-1:0]  avg_re;
  logic signed [SUM_W-1:0]  avg_im;
  logic [4:0]               avg_shift;
  logic                     s1_fire;
  logic                     s1_emit;

  logic signed [SUM_W-1:0]       real_sum_r;
  logic signed [SUM_W-1:0]       imag_sum_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_real_r;
  logic signed [SAMPLE_BITS-1:0] out_imag_r;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_out(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] c;
    if (v > SAT_MAX) begin
      c = SAT_MAX;
    end else if (v < SAT_MIN) begin
      c = SAT_MIN;
    end else begin
      c = v;
    end
    return c[SAMPLE_BITS-1:0];
  endfunction

  assign prod_re = s1_sample_r * s1_coef_re_r;
  assign prod_im = s1_sample_r * s1_coef_im_r;
  assign sum_re  = real_sum_r + SUM_W'(prod_re);
  assign sum_im  = imag_sum_r + SUM_W'(prod_im);

  // Divide by N, rounding toward minus infinity
  assign avg_shift = 5'(sbdft_pkg::SHIFT_BASE) + 5'(s1_win_r);
  assign avg_re    = sum_re >>> avg_shift;
  assign avg_im    = sum_im >>> avg_shift;

  assign s1_fire = s1_v_r && s1_adv;
  assign s1_emit = s1_fire && s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      real_sum_r  <= '0;
      imag_sum_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_fire) begin
        // Clear at the window end so the next window starts from zero
        real_sum_r <= s1_last_r ? '0 : sum_re;
        imag_sum_r <= s1_last_r ? '0 : sum_im;
      end
      if (s1_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_emit) begin
      out_real_r <= sat_out(avg_re);
      out_imag_r <= sat_out(avg_im);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_real_part = out_real_r;
  assign out_imag_part = out_imag_r;

`ifndef SYNTHESIS
  // A window-ending sample never overwrites a result still waiting
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    s1_emit |-> (!out_valid_r || out_ready))
    else $error("window result overwrote a pending result");

  // Sums start from zero after every window end
  a_sums_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    s1_emit |=> (real_sum_r == '0 && imag_sum_r == '0))
    else $error("sums not cleared after window end");

  // Window position wraps to zero after a window-ending sample transfers
  a_index_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && last_in) |=> (sample_index_r == 5'd0))
    else $error("sample index did not wrap at window end");

  // A new result appears only right after a window-ending sample
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && !out_ready)) |-> $past(s1_emit))
    else $error("result appeared without a window end");
`endif

endmodule
